// ----- rtl/core/mrrt_pkg.sv -----
// Package for the multi-root radix tree table: sizes, item types, status codes
// and the command/status structs between the controller and the datapath.
// No dependencies.
`default_nettype none

package mrrt_pkg;

  localparam int LEVEL_BITS = 4;
  localparam int MAX_HEIGHT = 11;
  localparam int NODE_POOL  = 256;

  localparam int KEY_W      = 44;
  localparam int VALUE_W    = 64;

  localparam int NODE_W     = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
  localparam int NF_W       = $clog2(NODE_POOL + 1);
  localparam int STORE_DEPTH = NODE_POOL << LEVEL_BITS;
  localparam int ADDR_W     = NODE_W + LEVEL_BITS;
  localparam int LVL_W      = $clog2(MAX_HEIGHT + 1);
  localparam int ROOT_IDX_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_NULL_VAL  = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_TOO_LARGE = 3'd4
  } status_e;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_e;

  typedef struct packed {
    logic               kind;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [VALUE_W-1:0] value_out;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic    clear_step;      // write zero at the sweep address and advance
    logic    load;            // capture the input item
    logic    start;           // load height and root node
    logic    alloc_root;      // with start: take a fresh node as root
    logic    walk_rd;         // read the entry at the current slot
    logic    leaf_wr;         // write the item value into the leaf slot
    logic    descend;         // follow the child read from the store
    logic    alloc_child;     // link a fresh node at the current slot and follow it
    logic    res_set;         // capture the result
    status_e res_status;
    logic    res_take_value;  // result value from the read data, else zero
    logic    out_load;        // move the result into the output register
  } mrrt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic too_large;
    logic root_none;
    logic pool_empty;
    logic is_insert;
    logic level_one;
    logic child_none;
    logic rdata_zero;
    logic value_zero;
  } mrrt_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/mrrt_datapath.sv -----
// Datapath of the radix tree table: item register, root table, node store,
// free-node counter, walk registers and the result/output registers.
// Depends on mrrt_pkg.
`default_nettype none

module mrrt_datapath import mrrt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  mrrt_cmd_t cmd_i,
  output mrrt_sts_t sts_o,
  output out_item_t out_data_o
);

  in_item_t            item_q;
  logic [LVL_W-1:0]    level_q;
  logic [NODE_W-1:0]   node_q;
  logic [NODE_W-1:0]   roots_q [MAX_HEIGHT];
  logic [NF_W-1:0]     next_free_q;
  logic [ADDR_W-1:0]   clr_addr_q;
  logic [VALUE_W-1:0]  mem_q [STORE_DEPTH];
  logic [VALUE_W-1:0]  rdata_q;
  out_item_t           res_q;
  out_item_t           out_q;

  logic [LVL_W-1:0]      height;
  logic [LVL_W-1:0]      height_m1;
  logic [LVL_W-1:0]      level_m1;
  logic [KEY_W-1:0]      key_sh;
  logic [LEVEL_BITS-1:0] grp;
  logic [ADDR_W-1:0]     slot;
  logic [NODE_W-1:0]     root;
  logic [NODE_W-1:0]     fresh_node;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_addr;
  logic [VALUE_W-1:0]    mem_wdata;

  // Smallest height whose key groups hold the whole key
  always_comb begin
    height = LVL_W'(MAX_HEIGHT);
    for (int i = MAX_HEIGHT - 1; i >= 1; i--) begin
      if ((item_q.key >> (i * LEVEL_BITS)) == '0) begin
        height = LVL_W'(i);
      end
    end
  end

  assign height_m1  = height - 1'b1;
  assign root       = roots_q[height_m1[ROOT_IDX_W-1:0]];
  assign fresh_node = next_free_q[NODE_W-1:0];

  assign level_m1  = level_q - 1'b1;
  assign key_sh    = item_q.key >> (level_m1 * LEVEL_BITS);
  assign grp       = key_sh[LEVEL_BITS-1:0];
  assign slot      = {node_q, grp};

  assign mem_we    = cmd_i.clear_step | cmd_i.leaf_wr | cmd_i.alloc_child;
  assign mem_addr  = cmd_i.clear_step ? clr_addr_q : slot;

  always_comb begin
    mem_wdata = '0;
    if (cmd_i.leaf_wr) begin
      mem_wdata = item_q.value;
    end else if (cmd_i.alloc_child) begin
      mem_wdata = VALUE_W'(fresh_node);
    end
  end

  assign sts_o.clear_last = (clr_addr_q == ADDR_W'(STORE_DEPTH - 1));
  assign sts_o.too_large  = (item_q.key >> (LEVEL_BITS * MAX_HEIGHT)) != '0;
  assign sts_o.root_none  = (root == '0);
  assign sts_o.pool_empty = (next_free_q >= NF_W'(NODE_POOL));
  assign sts_o.is_insert  = (item_q.kind == KIND_INSERT);
  assign sts_o.level_one  = (level_q == LVL_W'(1));
  assign sts_o.child_none = (rdata_q == '0) || (rdata_q >= VALUE_W'(NODE_POOL));
  assign sts_o.rdata_zero = (rdata_q == '0);
  assign sts_o.value_zero = (item_q.value == '0);

  // Control state: roots, free counter, sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roots_q     <= '{default: '0};
      next_free_q <= NF_W'(1);
      clr_addr_q  <= '0;
    end else begin
      if (cmd_i.clear_step) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (cmd_i.start && cmd_i.alloc_root) begin
        roots_q[height_m1[ROOT_IDX_W-1:0]] <= fresh_node;
      end
      if ((cmd_i.start && cmd_i.alloc_root) || cmd_i.alloc_child) begin
        next_free_q <= next_free_q + 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.start) begin
      level_q <= height;
      node_q  <= cmd_i.alloc_root ? fresh_node : root;
    end
    if (cmd_i.descend) begin
      level_q <= level_m1;
      node_q  <= rdata_q[NODE_W-1:0];
    end
    if (cmd_i.alloc_child) begin
      level_q <= level_m1;
      node_q  <= fresh_node;
    end
    if (cmd_i.res_set) begin
      res_q.status    <= cmd_i.res_status;
      res_q.value_out <= cmd_i.res_take_value ? rdata_q : '0;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  // Node store: one port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (cmd_i.walk_rd) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ----- rtl/core/mrrt_ctrl.sv -----
// Controller of the radix tree table: sequences the store sweep, the tree walk
// and result delivery, and drives the handshakes.
// Depends on mrrt_pkg.
`default_nettype none

module mrrt_ctrl import mrrt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  mrrt_sts_t sts_i,
  output mrrt_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_CLEAR     = 7'b0000001,
    S_IDLE      = 7'b0000010,
    S_HEIGHT    = 7'b0000100,
    S_WALK      = 7'b0001000,
    S_EVAL      = 7'b0010000,
    S_LEAF_WAIT = 7'b0100000,
    S_RESULT    = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_HEIGHT;
        end
      end
      S_HEIGHT: begin
        priority if (sts_i.too_large) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_TOO_LARGE;
          state_d          = S_RESULT;
        end else if (sts_i.root_none && !sts_i.is_insert) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_NOT_FOUND;
          state_d          = S_RESULT;
        end else if (sts_i.root_none && sts_i.pool_empty) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_EXHAUSTED;
          state_d          = S_RESULT;
        end else begin
          cmd_o.start      = 1'b1;
          cmd_o.alloc_root = sts_i.root_none;
          state_d          = S_WALK;
        end
      end
      S_WALK: begin
        if (sts_i.level_one && sts_i.is_insert) begin
          cmd_o.leaf_wr    = 1'b1;
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = sts_i.value_zero ? ST_NULL_VAL : ST_OK;
          state_d          = S_RESULT;
        end else begin
          cmd_o.walk_rd = 1'b1;
          state_d       = sts_i.level_one ? S_LEAF_WAIT : S_EVAL;
        end
      end
      S_EVAL: begin
        priority if (!sts_i.child_none) begin
          cmd_o.descend = 1'b1;
          state_d       = S_WALK;
        end else if (!sts_i.is_insert) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_NOT_FOUND;
          state_d          = S_RESULT;
        end else if (sts_i.pool_empty) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_EXHAUSTED;
          state_d          = S_RESULT;
        end else begin
          cmd_o.alloc_child = 1'b1;
          state_d           = S_WALK;
        end
      end
      S_LEAF_WAIT: begin
        cmd_o.res_set        = 1'b1;
        cmd_o.res_status     = sts_i.rdata_zero ? ST_NOT_FOUND : ST_OK;
        cmd_o.res_take_value = !sts_i.rdata_zero;
        state_d              = S_RESULT;
      end
      S_RESULT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/core/multi_root_radix_tree_table.sv -----
// Multi-root radix tree key-value table, top level.
// Each tree level above the leaf takes a store read and a decide step; an insert
// then writes the item value into the leaf, a lookup reads the leaf and decides on it.
// One item at a time: the next item is taken the cycle after the result moves
// to the output register; a key's tree height is at most 11.
// After reset a sweep zeroes the 4096-entry node store, with ready low.
`default_nettype none

module multi_root_radix_tree_table import mrrt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  mrrt_cmd_t cmd;
  mrrt_sts_t sts;

  mrrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mrrt_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while another is in work");

  a_alloc_has_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.alloc_child || (cmd.start && cmd.alloc_root) |-> !sts.pool_empty)
    else $error("node taken from an empty pool");

  a_leaf_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.leaf_wr |-> sts.level_one && sts.is_insert)
    else $error("leaf write off the leaf level or on a lookup");

  a_value_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |-> out_data_o.value_out == '0)
    else $error("nonzero value with a failing status");

endmodule

`default_nettype wire
